// ===== rtl/mafp_pkg.sv =====
// Package with the types, character codes and limits of the meter answer frame parser.
package mafp_pkg;

	localparam int unsigned IDENT_MAX = 16;
	localparam int unsigned MAN_BYTES = 3;

	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	localparam logic [1:0] KIND_IDENT   = 2'd0;
	localparam logic [1:0] KIND_ADDRESS = 2'd1;
	localparam logic [1:0] KIND_DATA    = 2'd2;

	localparam logic [1:0] KIND_RESET  = KIND_DATA;
	localparam logic [7:0] LIMIT_RESET = 8'd32;

	localparam logic [0:0] REG_KIND  = 1'b0;
	localparam logic [0:0] REG_LIMIT = 1'b1;

	localparam logic [1:0] TAG_MAN   = 2'd0;
	localparam logic [1:0] TAG_BAUD  = 2'd1;
	localparam logic [1:0] TAG_IDENT = 2'd2;
	localparam logic [1:0] TAG_VALUE = 2'd3;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_HEADER     = 3'd1;
	localparam logic [2:0] ERR_TOO_LONG   = 3'd2;
	localparam logic [2:0] ERR_TERMINATOR = 3'd3;
	localparam logic [2:0] ERR_CHECK      = 3'd4;

	typedef enum logic [12:0] {
		PH_IDLE     = 13'b0000000000001,
		PH_ID_MAN   = 13'b0000000000010,
		PH_ID_BAUD  = 13'b0000000000100,
		PH_ID_IDENT = 13'b0000000001000,
		PH_ID_LF    = 13'b0000000010000,
		PH_AD_P     = 13'b0000000100000,
		PH_AD_0     = 13'b0000001000000,
		PH_AD_STX   = 13'b0000010000000,
		PH_AD_LPAR  = 13'b0000100000000,
		PH_AD_PAY   = 13'b0001000000000,
		PH_AD_ETX   = 13'b0010000000000,
		PH_BCC      = 13'b0100000000000,
		PH_DA_PAY   = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic [1:0] data_tag;
		logic       frame_done;
		logic       frame_ok;
		logic [2:0] error_code;
	} result_t;

endpackage

// ===== rtl/meter_answer_frame_parser_top.sv =====
// Meter answer frame parser: byte stream in, tagged payload and frame status out.
//
// Channel   Direction  Request moves                    Notes
// s_axis    in         one received byte                tdata[7:0] rx_byte
// m_axis    out        one result per received byte     tlast frame_done, tuser tag/valid
// apb       in         register write or read           0x0 message_kind, 0x4 payload_limit
//
// Each byte passes an input register, then the phase update and 7-bit check add, then the
// result register, sustaining one byte per cycle while m_axis does not stall.
// The phase register, byte count and running check are the only loop; they update only on a load.
// Reset clears the phase to idle and the registers to kind 2 and limit 32.
// A stall on m_axis holds the result register; the input register still fills behind it.
module meter_answer_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [8] frame_ok, [11:9] error_code, zeros
	output logic [2:0]  m_axis_tuser,   // [0] data_valid, [2:1] data_tag
	output logic        m_axis_tlast,   // frame_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]           kind_q;
	logic [7:0]           limit_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 valid_s2;
	mafp_pkg::result_t    res_s2;
	mafp_pkg::result_t    res_d;
	mafp_pkg::phase_t     phase_q;
	mafp_pkg::phase_t     phase_d;
	logic [7:0]           count_q;
	logic [7:0]           count_d;
	logic [6:0]           check_q;
	logic [6:0]           check_d;
	logic                 advance;
	logic                 load;
	logic                 cfg_write;
	logic [7:0]           want;
	logic                 fixed_ok;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= mafp_pkg::KIND_RESET;
			limit_q <= mafp_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == mafp_pkg::REG_KIND) begin
				kind_q <= pwdata[1:0];
			end else begin
				limit_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == mafp_pkg::REG_KIND) begin
			prdata = {30'd0, kind_q};
		end else begin
			prdata = {24'd0, limit_q};
		end
	end

	assign advance       = !valid_s2 || m_axis_tready;
	assign load          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		case (phase_q)
			mafp_pkg::PH_AD_P:    want = mafp_pkg::CH_P;
			mafp_pkg::PH_AD_0:    want = mafp_pkg::CH_ZERO;
			mafp_pkg::PH_AD_STX:  want = mafp_pkg::CH_STX;
			default:              want = mafp_pkg::CH_LPAR;
		endcase
		fixed_ok = (byte_s1 == want);
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		check_d = check_q;
		res_d   = '0;
		case (phase_q)
			mafp_pkg::PH_IDLE: begin
				check_d = '0;
				count_d = '0;
				case (kind_q)
					mafp_pkg::KIND_IDENT: begin
						if (byte_s1 == mafp_pkg::CH_SLASH) phase_d = mafp_pkg::PH_ID_MAN;
						else res_d.error_code = mafp_pkg::ERR_HEADER;
					end
					mafp_pkg::KIND_ADDRESS: begin
						if (byte_s1 == mafp_pkg::CH_SOH) phase_d = mafp_pkg::PH_AD_P;
						else res_d.error_code = mafp_pkg::ERR_HEADER;
					end
					default: begin
						if (byte_s1 == mafp_pkg::CH_STX) phase_d = mafp_pkg::PH_DA_PAY;
						else res_d.error_code = mafp_pkg::ERR_HEADER;
					end
				endcase
			end
			mafp_pkg::PH_ID_MAN: begin
				res_d.data_valid = 1'b1;
				res_d.data_byte  = byte_s1;
				res_d.data_tag   = mafp_pkg::TAG_MAN;
				if (count_q + 8'd1 >= 8'(mafp_pkg::MAN_BYTES)) begin
					count_d = '0;
					phase_d = mafp_pkg::PH_ID_BAUD;
				end else begin
					count_d = count_q + 8'd1;
				end
			end
			mafp_pkg::PH_ID_BAUD: begin
				res_d.data_valid = 1'b1;
				res_d.data_byte  = byte_s1;
				res_d.data_tag   = mafp_pkg::TAG_BAUD;
				count_d          = '0;
				phase_d          = mafp_pkg::PH_ID_IDENT;
			end
			mafp_pkg::PH_ID_IDENT: begin
				if (byte_s1 == mafp_pkg::CH_CR) begin
					phase_d = mafp_pkg::PH_ID_LF;
				end else if (count_q >= 8'(mafp_pkg::IDENT_MAX)) begin
					res_d.error_code = mafp_pkg::ERR_TERMINATOR;
				end else begin
					res_d.data_valid = 1'b1;
					res_d.data_byte  = byte_s1;
					res_d.data_tag   = mafp_pkg::TAG_IDENT;
					count_d          = count_q + 8'd1;
				end
			end
			mafp_pkg::PH_ID_LF: begin
				res_d.frame_done = 1'b1;
				if (byte_s1 == mafp_pkg::CH_LF) res_d.frame_ok = 1'b1;
				else res_d.error_code = mafp_pkg::ERR_TERMINATOR;
			end
			mafp_pkg::PH_AD_P, mafp_pkg::PH_AD_0, mafp_pkg::PH_AD_STX,
			mafp_pkg::PH_AD_LPAR: begin
				if (!fixed_ok) begin
					res_d.error_code = mafp_pkg::ERR_HEADER;
				end else begin
					check_d = check_q + byte_s1[6:0];
					case (phase_q)
						mafp_pkg::PH_AD_P:   phase_d = mafp_pkg::PH_AD_0;
						mafp_pkg::PH_AD_0:   phase_d = mafp_pkg::PH_AD_STX;
						mafp_pkg::PH_AD_STX: phase_d = mafp_pkg::PH_AD_LPAR;
						default:             phase_d = mafp_pkg::PH_AD_PAY;
					endcase
				end
			end
			mafp_pkg::PH_AD_PAY, mafp_pkg::PH_DA_PAY: begin
				if ((phase_q == mafp_pkg::PH_AD_PAY && byte_s1 == mafp_pkg::CH_RPAR) ||
				    (phase_q == mafp_pkg::PH_DA_PAY && byte_s1 == mafp_pkg::CH_ETX)) begin
					check_d = check_q + byte_s1[6:0];
					phase_d = (phase_q == mafp_pkg::PH_AD_PAY) ? mafp_pkg::PH_AD_ETX
					                                            : mafp_pkg::PH_BCC;
				end else if (count_q >= limit_q) begin
					res_d.error_code = mafp_pkg::ERR_TOO_LONG;
				end else begin
					check_d          = check_q + byte_s1[6:0];
					res_d.data_valid = 1'b1;
					res_d.data_byte  = byte_s1;
					res_d.data_tag   = mafp_pkg::TAG_VALUE;
					count_d          = count_q + 8'd1;
				end
			end
			mafp_pkg::PH_AD_ETX: begin
				if (byte_s1 == mafp_pkg::CH_ETX) begin
					check_d = check_q + byte_s1[6:0];
					phase_d = mafp_pkg::PH_BCC;
				end else begin
					res_d.error_code = mafp_pkg::ERR_TERMINATOR;
				end
			end
			mafp_pkg::PH_BCC: begin
				res_d.frame_done = 1'b1;
				if (byte_s1 == {1'b0, check_q}) res_d.frame_ok = 1'b1;
				else res_d.error_code = mafp_pkg::ERR_CHECK;
			end
			default: begin
				phase_d          = mafp_pkg::PH_IDLE;
				res_d.error_code = mafp_pkg::ERR_HEADER;
			end
		endcase

		if (res_d.error_code != mafp_pkg::ERR_NONE) begin
			res_d.frame_done = 1'b1;
			res_d.frame_ok   = 1'b0;
		end
		if (res_d.frame_done) begin
			phase_d = mafp_pkg::PH_IDLE;
			count_d = '0;
			check_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mafp_pkg::PH_IDLE;
			count_q <= '0;
			check_q <= '0;
		end else if (load) begin
			phase_q <= phase_d;
			count_q <= count_d;
			check_q <= check_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, res_s2.error_code, res_s2.frame_ok, res_s2.data_byte};
	assign m_axis_tuser  = {res_s2.data_tag, res_s2.data_valid};
	assign m_axis_tlast  = res_s2.frame_done;

	a_ok_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.frame_ok) |-> (res_s2.frame_done &&
		res_s2.error_code == mafp_pkg::ERR_NONE))
		else $error("frame_ok without a clean frame end");

	a_error_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.error_code != mafp_pkg::ERR_NONE) |->
		(res_s2.frame_done && !res_s2.frame_ok && !res_s2.data_valid))
		else $error("error result does not end the frame cleanly");

	a_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res_d.frame_done) |=> (phase_q == mafp_pkg::PH_IDLE &&
		count_q == 8'd0 && check_q == 7'd0))
		else $error("parser not idle after a frame end");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(!load) |=> ($stable(phase_q) && $stable(count_q) && $stable(check_q)))
		else $error("parse state moved without a byte being processed");

endmodule
